@@ hw/rtl/amo_pkg.sv @@
`default_nettype none

package amo_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned WLEN = 32;
  localparam int unsigned MODE_W = 4;

  // Operation codes as they arrive on the request word.
  typedef enum logic [MODE_W-1:0] {
    OP_LR   = 4'd0,
    OP_SC   = 4'd1,
    OP_SWAP = 4'd2,
    OP_ADD  = 4'd3,
    OP_XOR  = 4'd4,
    OP_AND  = 4'd5,
    OP_OR   = 4'd6,
    OP_MIN  = 4'd7,
    OP_MAX  = 4'd8,
    OP_MINU = 4'd9,
    OP_MAXU = 4'd10,
    OP_NONE = 4'd15
  } amo_op_e;

  // Decoded operation handed from the front end to the execute side.
  typedef struct packed {
    amo_op_e          op;
    logic             is_double;
    logic [XLEN-1:0]  address;
    logic [XLEN-1:0]  operand;
    logic [XLEN-1:0]  loaded;
  } amo_item_t;

  // Sign-extend the low word of a value to the full register width.
  function automatic logic [XLEN-1:0] sext_word(input logic [XLEN-1:0] v);
    sext_word = {{(XLEN-WLEN){v[WLEN-1]}}, v[WLEN-1:0]};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/amo_req_if.sv @@
`default_nettype none

interface amo_req_if;
  logic                            valid;
  logic                            ready;
  logic [amo_pkg::MODE_W-1:0]      mode;
  logic                            is_double;
  logic [amo_pkg::XLEN-1:0]        address;
  logic [amo_pkg::XLEN-1:0]        operand;
  logic [amo_pkg::XLEN-1:0]        mem_data;

  modport source (output valid, mode, is_double, address, operand, mem_data, input ready);
  modport sink (input valid, mode, is_double, address, operand, mem_data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/amo_rsp_if.sv @@
`default_nettype none

interface amo_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        write_enable;
  logic [amo_pkg::XLEN-1:0]    write_data;
  logic [amo_pkg::XLEN-1:0]    dest_value;

  modport source (output valid, write_enable, write_data, dest_value, input ready);
  modport sink (input valid, write_enable, write_data, dest_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/atomic_memory_op_unit.sv @@
// Atomic memory operation unit for RV64A load-reserved, store-conditional
// and the read-modify-write operations, on words and doublewords.
// The request channel carries one word per instruction: mode, is_double,
// address, the source register operand and the current memory contents.
// The response channel returns one word per request, in order: the store
// enable, the store data (low word zero-extended for word accesses) and the
// destination value (old memory value, or the store-conditional flag).
// Both channels use valid/ready; a word moves when both are high.
// From request acceptance to response valid, a request passes the decode
// register, one queue slot and the output register in turn. One request
// is taken every cycle as long as responses are taken; the two-entry queue
// between decode and execute lets each side stall on its own.
// When the receiver stalls, the output register holds its word, the queue
// fills and request ready drops once decode, queue and output are full.
// Reset empties all stages and clears the reservation address to zero.
`default_nettype none

module atomic_memory_op_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  amo_req_if.sink    req_i,
  amo_rsp_if.source  rsp_o
);
  import amo_pkg::*;

  logic      fe_valid, fe_ready;
  amo_item_t fe_item;
  logic      be_valid, be_ready;
  amo_item_t be_item;

  amo_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .valid_o (fe_valid),
    .ready_i (fe_ready),
    .item_o  (fe_item)
  );

  amo_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_item_i  (fe_item),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_item_o   (be_item)
  );

  amo_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (be_valid),
    .ready_o (be_ready),
    .item_i  (be_item),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/amo_front.sv @@
`default_nettype none

module amo_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  amo_req_if.sink                  req_i,
  output      logic                valid_o,
  input  wire logic                ready_i,
  output      amo_pkg::amo_item_t  item_o
);
  import amo_pkg::*;

  logic      valid_q, valid_d;
  amo_item_t item_q, item_d;
  logic      accept;

  // The stage takes a new word when it is empty or its word moves on.
  assign req_i.ready = !valid_q || ready_i;
  assign accept      = req_i.valid && req_i.ready;

  // Classify the operation and bring both operands to full width.
  always_comb begin
    item_d           = item_q;
    valid_d          = valid_q && !ready_i;
    if (accept) begin
      valid_d        = 1'b1;
      if (req_i.mode > MODE_W'(OP_MAXU)) begin
        item_d.op    = OP_NONE;
      end else begin
        item_d.op    = amo_op_e'(req_i.mode);
      end
      item_d.is_double = req_i.is_double;
      item_d.address   = req_i.address;
      // Word operations work on sign-extended low words; the store data is
      // cut back to the low word later.
      item_d.operand   = req_i.is_double ? req_i.operand : sext_word(req_i.operand);
      item_d.loaded    = req_i.is_double ? req_i.mem_data : sext_word(req_i.mem_data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ hw/rtl/amo_queue.sv @@
`default_nettype none

module amo_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_valid_i,
  output      logic                push_ready_o,
  input  wire amo_pkg::amo_item_t  push_item_i,
  output      logic                pop_valid_o,
  input  wire logic                pop_ready_i,
  output      amo_pkg::amo_item_t  pop_item_o
);
  import amo_pkg::*;

  localparam int unsigned DEPTH = 2;

  amo_item_t   mem_q [DEPTH];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  assign push_ready_o = (count_q != 2'(DEPTH));
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/amo_back.sv @@
`default_nettype none

module amo_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output      logic                ready_o,
  input  wire amo_pkg::amo_item_t  item_i,
  amo_rsp_if.source                rsp_o
);
  import amo_pkg::*;

  logic            out_valid_q, out_valid_d;
  logic            we_q, we_d;
  logic [XLEN-1:0] wd_q, wd_d;
  logic [XLEN-1:0] dv_q, dv_d;
  logic [XLEN-1:0] resv_q, resv_d;
  logic [XLEN-1:0] result;
  logic            lt_s, lt_u, take;

  // A word executes when the output register is free or being emptied.
  assign ready_o = !out_valid_q || rsp_o.ready;
  assign take    = valid_i && ready_o;

  // Operands are already sign-extended for word accesses, so full-width
  // compares give the word ordering too.
  assign lt_s = $signed(item_i.loaded) < $signed(item_i.operand);
  assign lt_u = item_i.loaded < item_i.operand;

  // Read-modify-write result.
  always_comb begin
    case (item_i.op)
      OP_ADD:  result = item_i.loaded + item_i.operand;
      OP_XOR:  result = item_i.loaded ^ item_i.operand;
      OP_AND:  result = item_i.loaded & item_i.operand;
      OP_OR:   result = item_i.loaded | item_i.operand;
      OP_MIN:  result = lt_s ? item_i.loaded : item_i.operand;
      OP_MAX:  result = lt_s ? item_i.operand : item_i.loaded;
      OP_MINU: result = lt_u ? item_i.loaded : item_i.operand;
      OP_MAXU: result = lt_u ? item_i.operand : item_i.loaded;
      default: result = item_i.operand;
    endcase
  end

  // Store enable, store data, destination value and reservation update.
  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    we_d        = we_q;
    wd_d        = wd_q;
    dv_d        = dv_q;
    resv_d      = resv_q;
    if (take) begin
      out_valid_d = 1'b1;
      we_d        = 1'b0;
      wd_d        = '0;
      dv_d        = '0;
      case (item_i.op)
        OP_LR: begin
          dv_d   = item_i.loaded;
          resv_d = item_i.address;
        end
        OP_SC: begin
          if (item_i.address == resv_q) begin
            we_d = 1'b1;
            wd_d = item_i.operand;
          end else begin
            dv_d = XLEN'(1);
          end
        end
        OP_NONE: begin
          we_d = 1'b0;
        end
        default: begin
          we_d = 1'b1;
          wd_d = result;
          dv_d = item_i.loaded;
        end
      endcase
      // Word stores carry only the low word.
      if (!item_i.is_double) begin
        wd_d = {{(XLEN-WLEN){1'b0}}, wd_d[WLEN-1:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      resv_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      resv_q      <= resv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    we_q <= we_d;
    wd_q <= wd_d;
    dv_q <= dv_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.write_enable = we_q;
  assign rsp_o.write_data   = wd_q;
  assign rsp_o.dest_value   = dv_q;

endmodule

`default_nettype wire
